>>> rtl/scpa_pkg.sv
// shared types and constants for the sigma-clipped pose average
package scpa_pkg;
   localparam int MAX_SAMPLES_DEF = 512;
   localparam logic [9:0] SAMPLE_COUNT_RST = 10'd16;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [0:0] {
      CSR_SAMPLE_COUNT = 1'b0
   } csr_addr_type;

   typedef enum logic [0:0] {
      ST_OK = 1'b0,
      ST_EMPTY = 1'b1
   } status_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_LOAD,
      BK_SUM,
      BK_DEV,
      BK_KEEP,
      BK_DIV,
      BK_OUT
   } back_state_type;

   // one accepted sample passed from front to back
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               close;
      logic               horizontal;
   } sample_type;
endpackage

>>> rtl/sigma_clipped_pose_average.sv
// sigma-clipped pose average: loads a batch of samples, emits clipped means
// after a sample closes a batch, the back end makes three memory passes over it,
// then three 43-bit divides, skipped if none is kept
// throughput: one sample per cycle while a batch fills and busy is low; busy covers the batch pass
// results are strobed one cycle and cannot be stalled
// reset clears counters, votes and last stamp; the sample store is not cleared
module sigma_clipped_pose_average #(
   parameter int MAX_SAMPLES = scpa_pkg::MAX_SAMPLES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_stamp,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_mean_x,
   output logic signed [31:0] rsp_mean_y,
   output logic signed [31:0] rsp_mean_z,
   output logic [9:0]         rsp_kept_count,
   output logic               rsp_horizontal,
   output logic               rsp_status,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   logic [9:0] sample_count_ff;
   logic       push, pop, not_empty, full, back_busy, done, hold_ff;
   scpa_pkg::sample_type push_data, head;
   logic signed [31:0] mx, my, mz;
   logic [9:0] kc;
   logic hz, stv;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == scpa_pkg::CSR_SAMPLE_COUNT) ? {22'd0, sample_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) sample_count_ff <= scpa_pkg::SAMPLE_COUNT_RST;
      else if (psel && penable && pwrite && paddr[2] == scpa_pkg::CSR_SAMPLE_COUNT)
         sample_count_ff <= pwdata[9:0];
   end

   // stop taking samples once a closing one is queued until the back end finishes
   always_ff @(posedge clock) begin
      if (reset) hold_ff <= 1'b0;
      else if (push && push_data.close) hold_ff <= 1'b1;
      else if (done) hold_ff <= 1'b0;
   end
   assign busy = full || hold_ff;

   scpa_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
      .clock, .reset, .take(start && !busy), .stamp(req_stamp),
      .pos_x(req_pos_x), .pos_y(req_pos_y), .pos_z(req_pos_z),
      .quat_x(req_quat_x), .quat_y(req_quat_y), .quat_z(req_quat_z), .quat_w(req_quat_w),
      .sample_count(sample_count_ff), .push, .push_data
   );

   scpa_queue u_queue (
      .clock, .reset, .push, .push_data, .pop, .not_empty, .full, .head
   );

   scpa_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
      .clock, .reset, .avail(not_empty), .head, .pop, .busy(back_busy), .done,
      .mean_x(mx), .mean_y(my), .mean_z(mz), .kept_count(kc), .horizontal(hz),
      .status(stv)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= done;
      rsp_mean_x <= mx; rsp_mean_y <= my; rsp_mean_z <= mz;
      rsp_kept_count <= kc; rsp_horizontal <= hz; rsp_status <= stv;
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> back_busy) else $error("result outside batch pass");
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
`endif
endmodule

>>> rtl/scpa_front.sv
// front end: stamp filter, vote, batch close decision
module scpa_front #(
   parameter int MAX_SAMPLES = scpa_pkg::MAX_SAMPLES_DEF,
   parameter int CW = $clog2(MAX_SAMPLES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [31:0]         stamp,
   input  logic signed [31:0]  pos_x,
   input  logic signed [31:0]  pos_y,
   input  logic signed [31:0]  pos_z,
   input  logic signed [15:0]  quat_x,
   input  logic signed [15:0]  quat_y,
   input  logic signed [15:0]  quat_z,
   input  logic signed [15:0]  quat_w,
   input  logic [9:0]          sample_count,
   output logic                push,
   output scpa_pkg::sample_type push_data
);
   logic [31:0]   last_stamp_ff, last_stamp_in;
   logic [CW-1:0] filled_ff, filled_in;
   logic [CW-1:0] nsize, fill_next;
   logic signed [32:0] lhs, rhs;
   logic          new_stamp, close;

   always_comb begin
      new_stamp = take && (stamp != last_stamp_ff);
      if (sample_count == 10'd0) nsize = CW'(1);
      else if ({22'd0, sample_count} > 32'(MAX_SAMPLES)) nsize = CW'(MAX_SAMPLES);
      else nsize = CW'(sample_count);
      fill_next = (filled_ff >= CW'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES) : filled_ff + CW'(1);
      close = fill_next >= nsize;
      lhs = 33'(quat_x * quat_z) - 33'(quat_w * quat_y);
      rhs = 33'(quat_y * quat_z) + 33'(quat_w * quat_x);
      push = new_stamp;
      push_data.pos_x = pos_x;
      push_data.pos_y = pos_y;
      push_data.pos_z = pos_z;
      push_data.close = close;
      push_data.horizontal = lhs < rhs;
      last_stamp_in = last_stamp_ff;
      filled_in = filled_ff;
      if (new_stamp) begin
         last_stamp_in = close ? 32'd0 : stamp;
         filled_in = close ? '0 : fill_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_stamp_ff <= '0;
         filled_ff <= '0;
      end else begin
         last_stamp_ff <= last_stamp_in;
         filled_ff <= filled_in;
      end
   end
endmodule

>>> rtl/scpa_queue.sv
// short fifo between front and back
module scpa_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  scpa_pkg::sample_type push_data,
   input  logic                 pop,
   output logic                 not_empty,
   output logic                 full,
   output scpa_pkg::sample_type head
);
   localparam int D = scpa_pkg::QUEUE_DEPTH;
   localparam int AW = $clog2(D);
   scpa_pkg::sample_type mem_ff [D];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;

   assign not_empty = cnt_ff != '0;
   assign full = cnt_ff == (AW+1)'(D);
   assign head = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + AW'(1);
         if (pop) rp_ff <= rp_ff + AW'(1);
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule

>>> rtl/scpa_back.sv
// back end: sample store, batch statistics, clipping and means
module scpa_back #(
   parameter int MAX_SAMPLES = scpa_pkg::MAX_SAMPLES_DEF,
   parameter int CW = $clog2(MAX_SAMPLES + 1),
   parameter int AW = $clog2(MAX_SAMPLES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 avail,
   input  scpa_pkg::sample_type head,
   output logic                 pop,
   output logic                 busy,
   output logic                 done,
   output logic signed [31:0]   mean_x,
   output logic signed [31:0]   mean_y,
   output logic signed [31:0]   mean_z,
   output logic [9:0]           kept_count,
   output logic                 horizontal,
   output logic                 status
);
   localparam int SW = 32 + CW + 1;     // sums of positions
   localparam int DW = 32 + 2*CW + 2;   // n*z - S
   localparam int QW = 2*DW;            // d^2
   localparam int TW = QW + CW;         // sum of d^2, n*d^2
   localparam int HW = (32 + CW + 1) / 2; // half of |d|
   localparam int AHW = CW + HW;        // n times a half
   localparam int PW = AHW + HW;        // partial products

   logic signed [31:0] xs [MAX_SAMPLES];
   logic signed [31:0] ys [MAX_SAMPLES];
   logic signed [31:0] zs [MAX_SAMPLES];
   logic signed [31:0] rx_ff, ry_ff, rz_ff;

   scpa_pkg::back_state_type st_ff, st_in;
   logic [CW-1:0] fill_ff, fill_in, n_ff, n_in, idx_ff, idx_in, kept_ff, kept_in;
   logic [CW-1:0] hv_ff, hv_in, vv_ff, vv_in;
   logic          pass_ff, pass_in;   // 0: variance pass, 1: keep pass
   logic          rv_ff, rv_in;       // read data valid
   logic signed [SW-1:0] sz_ff, sz_in, sx_ff, sx_in, sy_ff, sy_in, sk_ff, sk_in;
   logic [TW-1:0] tot_ff, tot_in;
   logic [DW-1:0] d_ff, d_in;
   logic [QW-1:0] sq_ff, sq_in;
   logic          sqv_ff, sqv_in, dv_ff, dv_in, av_ff, av_in, pv_ff, pv_in;
   logic [HW-1:0] dh_ff, dh_in, dl_ff, dl_in;
   logic [AHW-1:0] ah_ff, ah_in, al_ff, al_in;
   logic [PW-1:0] phh_ff, phh_in, phl_ff, phl_in, pll_ff, pll_in;
   logic signed [31:0] dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in, px_ff, px_in;
   logic signed [31:0] py_ff, py_in, pz_ff, pz_in;
   logic signed [31:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic signed [31:0] bx_ff, bx_in, by_ff, by_in, bz_ff, bz_in;
   logic [1:0]    dsel_ff, dsel_in;
   logic [SW-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [6:0]    bit_ff, bit_in;
   logic [AW-1:0] waddr, raddr;
   logic          we, re;
   logic signed [CW+32:0] nz;
   logic signed [DW-1:0] dsig;
   logic signed [SW-1:0] num;
   logic [SW-1:0] mag, rsub;
   logic signed [31:0] qout;

   assign waddr = fill_ff[AW-1:0];
   assign raddr = idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (we) begin
         xs[waddr] <= head.pos_x;
         ys[waddr] <= head.pos_y;
         zs[waddr] <= head.pos_z;
      end
      rx_ff <= xs[raddr];
      ry_ff <= ys[raddr];
      rz_ff <= zs[raddr];
   end

   always_comb begin
      st_in = st_ff; fill_in = fill_ff; n_in = n_ff; idx_in = idx_ff; kept_in = kept_ff;
      hv_in = hv_ff; vv_in = vv_ff; pass_in = pass_ff; rv_in = 1'b0;
      sz_in = sz_ff; sx_in = sx_ff; sy_in = sy_ff; sk_in = sk_ff; tot_in = tot_ff;
      d_in = d_ff; sq_in = sq_ff; sqv_in = 1'b0; dv_in = 1'b0; av_in = 1'b0; pv_in = 1'b0;
      dh_in = dh_ff; dl_in = dl_ff; ah_in = ah_ff; al_in = al_ff;
      phh_in = phh_ff; phl_in = phl_ff; pll_in = pll_ff;
      dx_in = dx_ff; dy_in = dy_ff; dz_in = dz_ff; px_in = px_ff; py_in = py_ff;
      pz_in = pz_ff; ax_in = ax_ff; ay_in = ay_ff; az_in = az_ff;
      bx_in = bx_ff; by_in = by_ff; bz_in = bz_ff;
      dsel_in = dsel_ff; rem_in = rem_ff; quo_in = quo_ff;
      bit_in = bit_ff;
      pop = 1'b0; we = 1'b0; re = 1'b0; done = 1'b0;
      nz = (CW+33)'(signed'({1'b0, n_ff})) * (CW+33)'(rz_ff);
      dsig = DW'(nz) - DW'(sz_ff);
      num = (dsel_ff == 2'd0) ? sx_ff : (dsel_ff == 2'd1) ? sy_ff : sk_ff;
      mag = num[SW-1] ? SW'(-num) : SW'(num);
      rsub = {rem_ff[SW-2:0], quo_ff[SW-1]} - SW'(kept_ff);
      qout = 32'((num[SW-1] ? -signed'(quo_ff) : signed'(quo_ff)));
      unique case (st_ff)
         scpa_pkg::BK_IDLE: begin
            if (avail) begin
               pop = 1'b1; we = 1'b1;
               if (head.horizontal) hv_in = hv_ff + CW'(1);
               else vv_in = vv_ff + CW'(1);
               if (fill_ff < CW'(MAX_SAMPLES - 1)) fill_in = fill_ff + CW'(1);
               else fill_in = CW'(MAX_SAMPLES - 1);
               if (head.close) begin
                  n_in = fill_ff + CW'(1);
                  idx_in = '0; sz_in = '0; st_in = scpa_pkg::BK_SUM;
               end
            end
         end
         scpa_pkg::BK_SUM: begin
            // first pass: sum of heights
            if (rv_ff) sz_in = sz_ff + SW'(rz_ff);
            if (idx_ff < n_ff) begin
               rv_in = 1'b1; idx_in = idx_ff + CW'(1);
            end else if (!rv_ff) begin
               idx_in = '0; tot_in = '0; pass_in = 1'b0; st_in = scpa_pkg::BK_DEV;
               sx_in = '0; sy_in = '0; sk_in = '0; kept_in = '0;
            end
         end
         scpa_pkg::BK_DEV: begin
            // read -> deviation -> halves -> partial products -> sum -> accumulate or compare
            if (rv_ff) begin
               d_in = dsig[DW-1] ? DW'(-dsig) : DW'(dsig);
               px_in = rx_ff; py_in = ry_ff; pz_in = rz_ff; dv_in = 1'b1;
            end
            if (dv_ff) begin
               dh_in = d_ff[2*HW-1:HW]; dl_in = d_ff[HW-1:0];
               // keep pass scales one factor by n to form n*d^2
               ah_in = pass_ff ? AHW'(n_ff) * AHW'(d_ff[2*HW-1:HW]) : AHW'(d_ff[2*HW-1:HW]);
               al_in = pass_ff ? AHW'(n_ff) * AHW'(d_ff[HW-1:0]) : AHW'(d_ff[HW-1:0]);
               ax_in = px_ff; ay_in = py_ff; az_in = pz_ff; av_in = 1'b1;
            end
            if (av_ff) begin
               phh_in = PW'(ah_ff) * PW'(dh_ff);
               phl_in = PW'(ah_ff) * PW'(dl_ff);
               pll_in = PW'(al_ff) * PW'(dl_ff);
               bx_in = ax_ff; by_in = ay_ff; bz_in = az_ff; pv_in = 1'b1;
            end
            if (pv_ff) begin
               sq_in = (QW'(phh_ff) << (2*HW)) + (QW'(phl_ff) << (HW+1)) + QW'(pll_ff);
               sqv_in = 1'b1;
               dx_in = bx_ff; dy_in = by_ff; dz_in = bz_ff;
            end
            if (sqv_ff) begin
               if (!pass_ff) tot_in = tot_ff + TW'(sq_ff);
               else if (TW'(sq_ff) < tot_ff) begin
                  sx_in = sx_ff + SW'(dx_ff); sy_in = sy_ff + SW'(dy_ff);
                  sk_in = sk_ff + SW'(dz_ff); kept_in = kept_ff + CW'(1);
               end
            end
            if (idx_ff < n_ff) begin
               rv_in = 1'b1; idx_in = idx_ff + CW'(1);
            end else if (!rv_ff && !dv_ff && !av_ff && !pv_ff && !sqv_ff) begin
               idx_in = '0;
               if (!pass_ff) pass_in = 1'b1;
               else begin
                  dsel_in = 2'd0; rem_in = '0; quo_in = '0; bit_in = '0;
                  st_in = (kept_ff == '0) ? scpa_pkg::BK_OUT : scpa_pkg::BK_KEEP;
               end
            end
         end
         scpa_pkg::BK_KEEP: begin
            // load |sum| + kept/2 into the divider
            quo_in = mag + SW'(kept_ff >> 1); rem_in = '0; bit_in = '0;
            st_in = scpa_pkg::BK_DIV;
         end
         scpa_pkg::BK_DIV: begin
            // restoring division, one quotient bit a cycle
            if (!rsub[SW-1] || rem_ff[SW-1]) rem_in = rsub;
            else rem_in = {rem_ff[SW-2:0], quo_ff[SW-1]};
            quo_in = {quo_ff[SW-2:0], !rsub[SW-1] || rem_ff[SW-1]};
            bit_in = bit_ff + 7'd1;
            if (bit_ff == 7'(SW - 1)) begin
               unique case (dsel_ff)
                  2'd0: st_in = scpa_pkg::BK_LOAD;
                  2'd1: st_in = scpa_pkg::BK_LOAD;
                  default: st_in = scpa_pkg::BK_LOAD;
               endcase
            end
         end
         scpa_pkg::BK_LOAD: begin
            unique case (dsel_ff)
               2'd0: dx_in = qout;
               2'd1: dy_in = qout;
               default: dz_in = qout;
            endcase
            if (dsel_ff == 2'd2) st_in = scpa_pkg::BK_OUT;
            else begin
               dsel_in = dsel_ff + 2'd1; st_in = scpa_pkg::BK_KEEP;
            end
         end
         scpa_pkg::BK_OUT: begin
            done = 1'b1;
            fill_in = '0; hv_in = '0; vv_in = '0; st_in = scpa_pkg::BK_IDLE;
         end
         default: st_in = scpa_pkg::BK_IDLE;
      endcase
      re = rv_in;
   end

   assign busy = st_ff != scpa_pkg::BK_IDLE;
   assign mean_x = (kept_ff == '0) ? 32'sd0 : dx_ff;
   assign mean_y = (kept_ff == '0) ? 32'sd0 : dy_ff;
   assign mean_z = (kept_ff == '0) ? 32'sd0 : dz_ff;
   assign kept_count = 10'(kept_ff);
   assign horizontal = hv_ff > vv_ff;
   assign status = (kept_ff == '0) ? scpa_pkg::ST_EMPTY : scpa_pkg::ST_OK;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= scpa_pkg::BK_IDLE;
         fill_ff <= '0; hv_ff <= '0; vv_ff <= '0;
         rv_ff <= 1'b0; dv_ff <= 1'b0; av_ff <= 1'b0; pv_ff <= 1'b0; sqv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         fill_ff <= fill_in; hv_ff <= hv_in; vv_ff <= vv_in;
         rv_ff <= rv_in && re; dv_ff <= dv_in; av_ff <= av_in; pv_ff <= pv_in;
         sqv_ff <= sqv_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in; idx_ff <= idx_in; kept_ff <= kept_in; pass_ff <= pass_in;
      sz_ff <= sz_in; sx_ff <= sx_in; sy_ff <= sy_in; sk_ff <= sk_in; tot_ff <= tot_in;
      d_ff <= d_in; sq_ff <= sq_in; dx_ff <= dx_in; dy_ff <= dy_in; dz_ff <= dz_in;
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in; dsel_ff <= dsel_in;
      dh_ff <= dh_in; dl_ff <= dl_in; ah_ff <= ah_in; al_ff <= al_in;
      phh_ff <= phh_in; phl_ff <= phl_in; pll_ff <= pll_in;
      ax_ff <= ax_in; ay_ff <= ay_in; az_ff <= az_in;
      bx_ff <= bx_in; by_ff <= by_in; bz_ff <= bz_in;
      rem_ff <= rem_in; quo_ff <= quo_in; bit_ff <= bit_in;
   end
endmodule

>>> tb/tb_sigma_clipped_pose_average.sv
// testbench for the sigma-clipped pose average: random and directed pose words, scoreboard check
`timescale 1ns / 1ps

module tb_sigma_clipped_pose_average;
   localparam int STORE_DEPTH = 512;
   localparam int IDLE_LIMIT = 40000;

   typedef struct {
      logic [31:0]        stamp;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic signed [15:0] qw;
   } pose_word_type;

   typedef struct {
      logic signed [31:0]   mean_x;
      logic signed [31:0]   mean_y;
      logic signed [31:0]   mean_z;
      logic [9:0]           kept;
      logic                 horiz;
      scpa_pkg::status_type st;
   } batch_mean_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [31:0]        req_stamp = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic signed [15:0] req_quat_x = '0;
   logic signed [15:0] req_quat_y = '0;
   logic signed [15:0] req_quat_z = '0;
   logic signed [15:0] req_quat_w = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_mean_x;
   logic signed [31:0] rsp_mean_y;
   logic signed [31:0] rsp_mean_z;
   logic [9:0]         rsp_kept_count;
   logic               rsp_horizontal;
   logic               rsp_status;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   sigma_clipped_pose_average DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_stamp(req_stamp), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z), .req_quat_x(req_quat_x), .req_quat_y(req_quat_y),
      .req_quat_z(req_quat_z), .req_quat_w(req_quat_w),
      .rsp_valid(rsp_valid), .rsp_mean_x(rsp_mean_x), .rsp_mean_y(rsp_mean_y),
      .rsp_mean_z(rsp_mean_z), .rsp_kept_count(rsp_kept_count),
      .rsp_horizontal(rsp_horizontal), .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   pose_word_type  pending_words[$];
   batch_mean_type batch_means[$];

   // predictor copy of the block state
   int          pos_x_mem[STORE_DEPTH];
   int          pos_y_mem[STORE_DEPTH];
   int          pos_z_mem[STORE_DEPTH];
   int          batch_fill = 0;
   int          horiz_votes = 0;
   int          vert_votes = 0;
   logic [31:0] prev_stamp = '0;
   logic [9:0]  batch_size_reg = scpa_pkg::SAMPLE_COUNT_RST;

   int          errors = 0;
   int          idle_cycles = 0;
   int          burst_left = 8;
   int          gap_left = 0;
   logic [31:0] next_stamp = 32'd1000;
   logic signed [31:0] z_center = '0;

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic [31:0] rounded_mean(logic signed [63:0] s, int k);
      logic [63:0] m;
      logic [63:0] q;
      m = (s < 0) ? -s : s;
      q = (m + k / 2) / k;
      return (s < 0) ? 32'(-q) : 32'(q);
   endfunction

   task automatic absorb_word(pose_word_type p);
      logic signed [63:0]  lhs_v;
      logic signed [63:0]  rhs_v;
      logic signed [127:0] sum_z;
      logic signed [127:0] dev;
      logic signed [127:0] total;
      logic signed [63:0]  sx;
      logic signed [63:0]  sy;
      logic signed [63:0]  sk;
      int eff;
      int n;
      int k;
      batch_mean_type r;
      if (p.stamp == prev_stamp) return;
      prev_stamp = p.stamp;
      if (batch_fill >= STORE_DEPTH) batch_fill = STORE_DEPTH - 1;
      pos_x_mem[batch_fill] = p.x;
      pos_y_mem[batch_fill] = p.y;
      pos_z_mem[batch_fill] = p.z;
      batch_fill++;
      lhs_v = p.qx * p.qz - p.qw * p.qy;
      rhs_v = p.qy * p.qz + p.qw * p.qx;
      if (lhs_v < rhs_v) horiz_votes++;
      else vert_votes++;
      eff = (batch_size_reg == 0) ? 1 : int'(batch_size_reg);
      if (eff > STORE_DEPTH) eff = STORE_DEPTH;
      if (batch_fill < eff) return;
      n = batch_fill;
      sum_z = 0;
      for (int i = 0; i < n; i++) sum_z += pos_z_mem[i];
      total = 0;
      for (int i = 0; i < n; i++) begin
         dev = n * pos_z_mem[i] - sum_z;
         total += dev * dev;
      end
      sx = 0; sy = 0; sk = 0; k = 0;
      // keep iff n*d^2 < sum d^2, exact form of the variance bound
      for (int i = 0; i < n; i++) begin
         dev = n * pos_z_mem[i] - sum_z;
         if (n * dev * dev < total) begin
            sx += pos_x_mem[i];
            sy += pos_y_mem[i];
            sk += pos_z_mem[i];
            k++;
         end
      end
      if (k > 0) begin
         r.mean_x = rounded_mean(sx, k);
         r.mean_y = rounded_mean(sy, k);
         r.mean_z = rounded_mean(sk, k);
         r.st = scpa_pkg::ST_OK;
      end else begin
         r.mean_x = '0;
         r.mean_y = '0;
         r.mean_z = '0;
         r.st = scpa_pkg::ST_EMPTY;
      end
      r.kept = 10'(k);
      r.horiz = horiz_votes > vert_votes;
      batch_means.push_back(r);
      batch_fill = 0;
      horiz_votes = 0;
      vert_votes = 0;
      prev_stamp = '0;
   endtask

   // driver: words in bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            absorb_word(pending_words[0]);
            void'(pending_words.pop_front());
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_words.size() > 0) begin
            start <= 1'b1;
            req_stamp <= pending_words[0].stamp;
            req_pos_x <= pending_words[0].x;
            req_pos_y <= pending_words[0].y;
            req_pos_z <= pending_words[0].z;
            req_quat_x <= pending_words[0].qx;
            req_quat_y <= pending_words[0].qy;
            req_quat_z <= pending_words[0].qz;
            req_quat_w <= pending_words[0].qw;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (batch_means.size() == 0) begin
            report("unexpected result", 0, 0);
         end else begin
            if (rsp_mean_x !== batch_means[0].mean_x)
               report("mean_x", rsp_mean_x, batch_means[0].mean_x);
            if (rsp_mean_y !== batch_means[0].mean_y)
               report("mean_y", rsp_mean_y, batch_means[0].mean_y);
            if (rsp_mean_z !== batch_means[0].mean_z)
               report("mean_z", rsp_mean_z, batch_means[0].mean_z);
            if (rsp_kept_count !== batch_means[0].kept)
               report("kept_count", rsp_kept_count, batch_means[0].kept);
            if (rsp_horizontal !== batch_means[0].horiz)
               report("horizontal", rsp_horizontal, batch_means[0].horiz);
            if (rsp_status !== batch_means[0].st)
               report("status", rsp_status, batch_means[0].st);
            void'(batch_means.pop_front());
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_sigma_clipped_pose_average failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic add_word(logic [31:0] s, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic signed [15:0] qx,
                           logic signed [15:0] qy, logic signed [15:0] qz,
                           logic signed [15:0] qw);
      pose_word_type p;
      p.stamp = s; p.x = x; p.y = y; p.z = z;
      p.qx = qx; p.qy = qy; p.qz = qz; p.qw = qw;
      pending_words.push_back(p);
   endtask

   task automatic add_random_word();
      logic [31:0] s;
      logic signed [31:0] z;
      int sel;
      sel = $urandom % 10;
      if (sel == 0) s = next_stamp;               // repeated stamp
      else if (sel == 1) s = '0;
      else begin
         next_stamp = ($urandom % 8 == 0) ? $urandom : next_stamp + $urandom_range(1, 50);
         s = next_stamp;
      end
      sel = $urandom % 6;
      if (sel == 0) z = $urandom;
      else if (sel == 1) z = z_center;
      else z = z_center + $signed($urandom_range(0, 64)) - 32;
      if ($urandom % 12 == 0)
         add_word(s, $urandom, $urandom, z, '0, '0, '0, '0);
      else
         add_word(s, $urandom, $urandom, z, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic write_batch_size(logic [9:0] v);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= 3'(4 * scpa_pkg::CSR_SAMPLE_COUNT); pwdata <= 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      batch_size_reg = v;
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || start || batch_means.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic run_phase(logic [9:0] size, int words);
      drain();
      write_batch_size(size);
      z_center = $urandom;
      for (int i = 0; i < words; i++) add_random_word();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed words, default batch of 16
      add_word(32'd0, 32'sd1, 32'sd2, 32'sd3, 16'sd1, 16'sd0, 16'sd0, 16'sd1);
      add_word(32'd1, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      add_word(32'd1, 32'sd5, 32'sd5, 32'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      add_word(32'd2, 32'h80000000, 32'h7fffffff, 32'h80000000,
               16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_word(32'hffffffff, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      add_word(32'hfffffffe, -32'sd1, -32'sd1, -32'sd1, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      add_word(32'd3, 32'sd100, -32'sd100, 32'sd10, 16'sd0, 16'sd16384, 16'sd0, 16'sd0);
      add_word(32'd4, 32'sd7, 32'sd9, 32'sd11, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384);
      for (int i = 0; i < 9; i++)
         add_word(32'd10 + i, $urandom, $urandom, 32'sd12 + i, $urandom, $urandom,
                  $urandom, $urandom);
      // single-sample batches: nothing kept
      run_phase(10'd1, 4);
      run_phase(10'd0, 4);
      // two samples never keep either one
      run_phase(10'd2, 6);
      // all heights equal
      drain();
      write_batch_size(10'd5);
      for (int i = 0; i < 5; i++)
         add_word(32'd50 + i, $urandom, $urandom, 32'sd777, $urandom, $urandom,
                  $urandom, $urandom);
      // oversized setting acts as the full store
      run_phase(10'h3ff, 515);
      for (int it = 0; it < 8; it++) begin
         run_phase(10'($urandom_range(1, 24)), $urandom_range(8, 60));
         if (($urandom % 3) == 0) run_phase(10'd3, 9);
      end
      run_phase(10'd512, 40);
      run_phase(10'd4, 40);
      drain();
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("tb_sigma_clipped_pose_average passed");
      end else begin
         $display("tb_sigma_clipped_pose_average failed");
      end
      $finish;
   end
endmodule
